FILE: hdl/tilemap_pixel_compose_unit_defines.svh
// Assertion helpers for the tile map pixel composer.
`ifndef TILEMAP_PIXEL_COMPOSE_UNIT_DEFINES_SVH
`define TILEMAP_PIXEL_COMPOSE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpc assertion failed");
`define TPC_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tpc assertion failed");
`else
`define TPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TPC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: hdl/tpc_pkg.sv
package tpc_pkg;

  typedef enum logic [1:0] {
    OP_MAP_WR   = 2'd0,
    OP_SHEET_WR = 2'd1,
    OP_FETCH    = 2'd2
  } op_e;

  localparam logic [2:0] REG_TILE_SIZE    = 3'd0;
  localparam logic [2:0] REG_MAP_WIDTH    = 3'd1;
  localparam logic [2:0] REG_MAP_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_SHEET_WIDTH  = 3'd3;
  localparam logic [2:0] REG_SHEET_HEIGHT = 3'd4;

  // operand width and stage count of the shift-subtract dividers
  localparam int unsigned DIV_W = 16;

  typedef struct packed {
    op_e         op;
    logic [13:0] idx;
    logic [31:0] val;
    logic        err;
  } front_t;

  typedef struct packed {
    op_e         op;
    logic [13:0] idx;
    logic [31:0] val;
    logic        err;
    logic [6:0]  rx;
    logic [6:0]  ry;
  } back_t;

endpackage

FILE: hdl/tpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
module tpc_div #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned W      = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [W-1:0]      num_i [LANES],
  input  logic [W-1:0]      den_i [LANES],
  input  logic [SIDE_W-1:0] side_i,
  output logic              out_valid_o,
  output logic [W-1:0]      quot_o [LANES],
  output logic [W-1:0]      rem_o [LANES],
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_s  [W+1];
  logic [W-1:0]      num_s  [W+1][LANES];
  logic [W-1:0]      den_s  [W+1][LANES];
  logic [W-1:0]      quo_s  [W+1][LANES];
  logic [W-1:0]      rem_s  [W+1][LANES];
  logic [SIDE_W-1:0] side_s [W+1];

  assign vld_s[0]  = in_valid_i;
  assign side_s[0] = side_i;
  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign num_s[0][l] = num_i[l];
    assign den_s[0][l] = den_i[l];
    assign quo_s[0][l] = '0;
    assign rem_s[0][l] = '0;
  end

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0]        trial [LANES];
    logic [W-1:0]      rem_d [LANES];
    logic [W-1:0]      quo_d [LANES];
    logic              vld_q;
    logic [W-1:0]      num_q [LANES];
    logic [W-1:0]      den_q [LANES];
    logic [W-1:0]      quo_q [LANES];
    logic [W-1:0]      rem_q [LANES];
    logic [SIDE_W-1:0] side_q;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_s[k][l], num_s[k][l][W-1-k]};
        if (trial[l] >= {1'b0, den_s[k][l]}) begin
          rem_d[l] = W'(trial[l] - {1'b0, den_s[k][l]});
          quo_d[l] = {quo_s[k][l][W-2:0], 1'b1};
        end else begin
          rem_d[l] = W'(trial[l]);
          quo_d[l] = {quo_s[k][l][W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q <= side_s[k];
      for (int l = 0; l < LANES; l++) begin
        num_q[l] <= num_s[k][l];
        den_q[l] <= den_s[k][l];
        quo_q[l] <= quo_d[l];
        rem_q[l] <= rem_d[l];
      end
    end

    assign vld_s[k+1]  = vld_q;
    assign side_s[k+1] = side_q;
    for (genvar l = 0; l < LANES; l++) begin : g_out
      assign num_s[k+1][l] = num_q[l];
      assign den_s[k+1][l] = den_q[l];
      assign quo_s[k+1][l] = quo_q[l];
      assign rem_s[k+1][l] = rem_q[l];
    end
  end

  assign out_valid_o = vld_s[W];
  assign side_o      = side_s[W];
  for (genvar l = 0; l < LANES; l++) begin : g_res
    assign quot_o[l] = quo_s[W][l];
    assign rem_o[l]  = rem_s[W][l];
  end

endmodule

FILE: hdl/tilemap_pixel_compose_unit.sv
// Tile map background pixel composer.
// Items enter on start_i whenever busy_o is low; busy_o stays low, so an item
// may be issued on every clock. op_i selects a tile map write (store_index_i,
// low 16 bits of write_value_i), a tile sheet write, or a pixel fetch at
// (pixel_x_i, pixel_y_i). Writes give no result.
// A fetch returns pixel_value_o / out_of_range_o with result_valid_o high for
// one cycle. Its path runs through two 16-stage divider pipelines
// (coordinate / tile size, tile number / tiles per sheet row), the map and
// sheet memory read stages and the multiply-add stages. Throughput is one
// item per cycle. Writes travel the same pipeline and update each store at
// the stage where it is read, so every fetch sees exactly the writes issued
// before it. Registers are written over cfg_valid_i/cfg_ready_o (always
// ready); the user must write them only while no item is in flight, as the
// block does not enforce it. Reset restores register defaults and empties
// the pipeline; store contents are undefined until written. The receiver
// cannot stall: each result must be taken in the cycle it is shown.
`include "tilemap_pixel_compose_unit_defines.svh"

module tilemap_pixel_compose_unit #(
  parameter int unsigned MAP_ENTRIES  = 1024,
  parameter int unsigned SHEET_PIXELS = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [13:0] store_index_i,
  input  logic [31:0] write_value_i,
  input  logic [15:0] pixel_x_i,
  input  logic [15:0] pixel_y_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [31:0] pixel_value_o,
  output logic        out_of_range_o
);

  localparam int unsigned DW      = tpc_pkg::DIV_W;
  localparam int unsigned MAW     = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int unsigned SAW     = (SHEET_PIXELS > 1) ? $clog2(SHEET_PIXELS) : 1;
  localparam int unsigned LATENCY = 2 * DW + 9;
  localparam int unsigned FW      = $bits(tpc_pkg::front_t);
  localparam int unsigned BW      = $bits(tpc_pkg::back_t);

  // configuration
  logic [6:0]  tile_size_q;
  logic [10:0] map_w_q, map_h_q;
  logic [14:0] sheet_w_q, sheet_h_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q <= 7'd8;
      map_w_q     <= 11'd32;
      map_h_q     <= 11'd32;
      sheet_w_q   <= 15'd128;
      sheet_h_q   <= 15'd128;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tpc_pkg::REG_TILE_SIZE:    tile_size_q <= cfg_data_i[6:0];
        tpc_pkg::REG_MAP_WIDTH:    map_w_q     <= cfg_data_i[10:0];
        tpc_pkg::REG_MAP_HEIGHT:   map_h_q     <= cfg_data_i[10:0];
        tpc_pkg::REG_SHEET_WIDTH:  sheet_w_q   <= cfg_data_i;
        tpc_pkg::REG_SHEET_HEIGHT: sheet_h_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 0: capture and image bounds check
  logic [17:0] lim_w, lim_h;
  logic        err0;
  assign lim_w = 18'(map_w_q) * 18'(tile_size_q);
  assign lim_h = 18'(map_h_q) * 18'(tile_size_q);
  assign err0  = (tile_size_q == '0) || (map_w_q == '0) || (map_h_q == '0) ||
                 ({2'b0, pixel_x_i} >= lim_w) || ({2'b0, pixel_y_i} >= lim_h);

  logic            s0_valid_q;
  tpc_pkg::front_t s0_q;
  logic [15:0]     s0_x_q, s0_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q.op  <= tpc_pkg::op_e'(op_i);
    s0_q.idx <= store_index_i;
    s0_q.val <= write_value_i;
    s0_q.err <= err0;
    s0_x_q   <= pixel_x_i;
    s0_y_q   <= pixel_y_i;
  end

  // x / ts, y / ts, sheet_w / ts
  logic [DW-1:0]   d1_num [3];
  logic [DW-1:0]   d1_den [3];
  logic [DW-1:0]   d1_quot [3];
  logic [DW-1:0]   d1_rem [3];
  logic            d1_valid;
  logic [FW-1:0]   d1_side;
  tpc_pkg::front_t d1_f;

  assign d1_num[0] = s0_x_q;
  assign d1_num[1] = s0_y_q;
  assign d1_num[2] = DW'(sheet_w_q);
  for (genvar l = 0; l < 3; l++) begin : g_d1den
    assign d1_den[l] = DW'(tile_size_q);
  end

  tpc_div #(.LANES(3), .W(DW), .SIDE_W(FW)) u_div_coord (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s0_valid_q),
    .num_i       (d1_num),
    .den_i       (d1_den),
    .side_i      (FW'(s0_q)),
    .out_valid_o (d1_valid),
    .quot_o      (d1_quot),
    .rem_o       (d1_rem),
    .side_o      (d1_side)
  );
  assign d1_f = tpc_pkg::front_t'(d1_side);

  // p1: row product, per-row count check
  logic           p1_valid_q;
  tpc_pkg::back_t p1_q;
  logic [15:0]    p1_qx_q;
  logic [14:0]    p1_prow_q;
  logic [26:0]    p1_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q.op   <= d1_f.op;
    p1_q.idx  <= d1_f.idx;
    p1_q.val  <= d1_f.val;
    p1_q.err  <= d1_f.err || (d1_quot[2][14:0] == '0);
    p1_q.rx   <= d1_rem[0][6:0];
    p1_q.ry   <= d1_rem[1][6:0];
    p1_qx_q   <= d1_quot[0];
    p1_prow_q <= d1_quot[2][14:0];
    p1_prod_q <= 27'(d1_quot[1]) * 27'(map_w_q);
  end

  // p2: map cell index
  logic           p2_valid_q;
  tpc_pkg::back_t p2_q, p2_d;
  logic [14:0]    p2_prow_q;
  logic [27:0]    p2_cell_q;
  logic [27:0]    cell_d;

  assign cell_d = 28'(p1_prod_q) + 28'(p1_qx_q);

  always_comb begin
    p2_d     = p1_q;
    p2_d.err = p1_q.err || (32'(cell_d) >= 32'(MAP_ENTRIES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q      <= p2_d;
    p2_prow_q <= p1_prow_q;
    p2_cell_q <= cell_d;
  end

  // m: tile map access (write or read, one per cycle)
  logic [15:0]    map_mem [MAP_ENTRIES];
  logic [15:0]    map_rdata_q;
  logic [31:0]    map_widx, map_ridx;
  logic           map_we;
  logic           m_valid_q;
  tpc_pkg::back_t m_q;
  logic [14:0]    m_prow_q;

  assign map_widx = 32'(p2_q.idx);
  assign map_ridx = 32'(p2_cell_q);
  assign map_we   = p2_valid_q && (p2_q.op == tpc_pkg::OP_MAP_WR) &&
                    (map_widx < 32'(MAP_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_widx[MAW-1:0]] <= p2_q.val[15:0];
    end
    map_rdata_q <= map_mem[map_ridx[MAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q      <= p2_q;
    m_prow_q <= p2_prow_q;
  end

  // tile number / tiles per sheet row
  logic [DW-1:0]  d2_num [1];
  logic [DW-1:0]  d2_den [1];
  logic [DW-1:0]  d2_quot [1];
  logic [DW-1:0]  d2_rem [1];
  logic           d2_valid;
  logic [BW-1:0]  d2_side;
  tpc_pkg::back_t d2_b;

  assign d2_num[0] = DW'(map_rdata_q);
  assign d2_den[0] = DW'(m_prow_q);

  tpc_div #(.LANES(1), .W(DW), .SIDE_W(BW)) u_div_tile (
    .clk_i,
    .rst_ni,
    .in_valid_i  (m_valid_q),
    .num_i       (d2_num),
    .den_i       (d2_den),
    .side_i      (BW'(m_q)),
    .out_valid_o (d2_valid),
    .quot_o      (d2_quot),
    .rem_o       (d2_rem),
    .side_o      (d2_side)
  );
  assign d2_b = tpc_pkg::back_t'(d2_side);

  // a1..a4: sheet position and linear address
  logic           a1_valid_q, a2_valid_q, a3_valid_q, a4_valid_q;
  tpc_pkg::back_t a1_q, a2_q, a3_q, a4_q, a2_d, a4_d;
  logic [22:0]    a1_px_q, a1_py_q;
  logic [23:0]    a2_sx_q, a2_sy_q, sx_d, sy_d, a3_sx_q;
  logic [38:0]    a3_prod_q;
  logic [39:0]    a4_addr_q, addr_d;

  assign sx_d   = 24'(a1_px_q) + 24'(a1_q.rx);
  assign sy_d   = 24'(a1_py_q) + 24'(a1_q.ry);
  assign addr_d = 40'(a3_prod_q) + 40'(a3_sx_q);

  always_comb begin
    a2_d     = a1_q;
    a2_d.err = a1_q.err || (sx_d >= 24'(sheet_w_q)) || (sy_d >= 24'(sheet_h_q));
    a4_d     = a3_q;
    a4_d.err = a3_q.err || (addr_d >= 40'(SHEET_PIXELS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_valid_q <= 1'b0;
      a2_valid_q <= 1'b0;
      a3_valid_q <= 1'b0;
      a4_valid_q <= 1'b0;
    end else begin
      a1_valid_q <= d2_valid;
      a2_valid_q <= a1_valid_q;
      a3_valid_q <= a2_valid_q;
      a4_valid_q <= a3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q      <= d2_b;
    a1_px_q   <= 23'(d2_rem[0]) * 23'(tile_size_q);
    a1_py_q   <= 23'(d2_quot[0]) * 23'(tile_size_q);
    a2_q      <= a2_d;
    a2_sx_q   <= sx_d;
    a2_sy_q   <= sy_d;
    a3_q      <= a2_q;
    a3_sx_q   <= a2_sx_q;
    a3_prod_q <= 39'(a2_sy_q) * 39'(sheet_w_q);
    a4_q      <= a4_d;
    a4_addr_q <= addr_d;
  end

  // s: tile sheet access and result
  logic [31:0] sheet_mem [SHEET_PIXELS];
  logic [31:0] sheet_rdata_q;
  logic [31:0] sheet_widx;
  logic        sheet_we;
  logic        s_valid_q;
  logic        s_fetch_q;
  logic        s_err_q;

  assign sheet_widx = 32'(a4_q.idx);
  assign sheet_we   = a4_valid_q && (a4_q.op == tpc_pkg::OP_SHEET_WR) &&
                      (sheet_widx < 32'(SHEET_PIXELS));

  always_ff @(posedge clk_i) begin
    if (sheet_we) begin
      sheet_mem[sheet_widx[SAW-1:0]] <= a4_q.val;
    end
    sheet_rdata_q <= sheet_mem[a4_addr_q[SAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= a4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_fetch_q <= (a4_q.op == tpc_pkg::OP_FETCH);
    s_err_q   <= a4_q.err;
  end

  assign result_valid_o = s_valid_q && s_fetch_q;
  assign out_of_range_o = s_err_q;
  assign pixel_value_o  = s_err_q ? '0 : sheet_rdata_q;

  `TPC_ASSERT_IMPL(a_result_has_fetch, clk_i, rst_ni, result_valid_o,
                   $past(start_i && !busy_o && (op_i == tpc_pkg::OP_FETCH), LATENCY))
  `TPC_ASSERT_IMPL(a_early_err_kept, clk_i, rst_ni,
                   result_valid_o && $past(s0_valid_q && s0_q.err, LATENCY - 1),
                   out_of_range_o)
  `TPC_ASSERT_NEVER(a_zero_tile_flagged, clk_i, rst_ni,
                    result_valid_o && !out_of_range_o && (tile_size_q == '0))

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned MAP_CELLS  = 1024;
  localparam int unsigned SHEET_SIZE = 16384;
  localparam int unsigned DRAIN_CYC  = 64;
  localparam longint unsigned CYCLE_LIMIT = 1_500_000;

  class pixel_scoreboard;
    bit [15:0] tile_map[MAP_CELLS];
    bit        map_loaded[MAP_CELLS];
    bit [31:0] sheet[SHEET_SIZE];
    bit        sheet_loaded[SHEET_SIZE];
    longint unsigned tsz, map_w, map_h, sheet_w, sheet_h;
    bit [32:0] pixel_q[$];
    int unsigned mismatches;

    function new();
      tsz = 8; map_w = 32; map_h = 32; sheet_w = 128; sheet_h = 128;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [14:0] d);
      case (idx)
        tpc_pkg::REG_TILE_SIZE:    tsz     = 64'(d[6:0]);
        tpc_pkg::REG_MAP_WIDTH:    map_w   = 64'(d[10:0]);
        tpc_pkg::REG_MAP_HEIGHT:   map_h   = 64'(d[10:0]);
        tpc_pkg::REG_SHEET_WIDTH:  sheet_w = 64'(d);
        tpc_pkg::REG_SHEET_HEIGHT: sheet_h = 64'(d);
        default: ;
      endcase
    endfunction

    // returns the error flag; map_cell / sheet_addr are -1 where no read happens
    function bit locate(longint unsigned x, longint unsigned y,
                        output int map_cell, output int sheet_addr);
      longint unsigned c, tn, per_row, sx, sy, a;
      map_cell = -1;
      sheet_addr = -1;
      if (tsz == 0 || map_w == 0 || map_h == 0) return 1;
      if (x >= map_w * tsz || y >= map_h * tsz) return 1;
      c = (y / tsz) * map_w + x / tsz;
      if (c >= MAP_CELLS) return 1;
      map_cell = int'(c);
      tn = 64'(tile_map[c]);
      per_row = sheet_w / tsz;
      if (per_row == 0) return 1;
      sx = (tn % per_row) * tsz + x % tsz;
      sy = (tn / per_row) * tsz + y % tsz;
      if (sx >= sheet_w || sy >= sheet_h) return 1;
      a = sy * sheet_w + sx;
      if (a >= SHEET_SIZE) return 1;
      sheet_addr = int'(a);
      return 0;
    endfunction

    // mostly tile numbers that land inside the sheet
    function bit [31:0] pick_tile();
      longint unsigned per_row, rows, top;
      per_row = (tsz == 0) ? 0 : sheet_w / tsz;
      rows = (tsz == 0) ? 0 : sheet_h / tsz;
      top = per_row * rows;
      if (top > 0 && $urandom_range(0, 9) < 8) begin
        if (top > 65536) top = 65536;
        return {16'($urandom_range(0, 65535)), 16'(longint'($urandom) % top)};
      end
      return $urandom;
    endfunction

    function void note_item(logic [1:0] op, logic [13:0] idx, logic [31:0] val,
                            logic [15:0] x, logic [15:0] y);
      int mc, sa;
      bit err;
      case (op)
        tpc_pkg::OP_MAP_WR: if (idx < MAP_CELLS) begin
          tile_map[idx] = val[15:0];
          map_loaded[idx] = 1;
        end
        tpc_pkg::OP_SHEET_WR: if (idx < SHEET_SIZE) begin
          sheet[idx] = val;
          sheet_loaded[idx] = 1;
        end
        tpc_pkg::OP_FETCH: begin
          err = locate(64'(x), 64'(y), mc, sa);
          pixel_q.push_back({err, err ? 32'd0 : sheet[sa]});
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] pix, logic oor);
      bit [32:0] want;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pix=%h oor=%b", pix, oor);
        return;
      end
      want = pixel_q.pop_front();
      if (pix !== want[31:0] || oor !== want[32]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp pix=%h oor=%b, got pix=%h oor=%b",
                   want[31:0], want[32], pix, oor);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  op_i = tpc_pkg::OP_FETCH;
  logic [13:0] store_index_i = '0;
  logic [31:0] write_value_i = '0;
  logic [15:0] pixel_x_i = '0;
  logic [15:0] pixel_y_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [14:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [31:0] pixel_value_o;
  logic        out_of_range_o;

  pixel_scoreboard sb = new();
  longint unsigned cycles = 0;
  bit no_gaps = 0;

  tilemap_pixel_compose_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && result_valid_o) sb.check_result(pixel_value_o, out_of_range_o);

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // called just after a rising edge; returns just after the transfer edge
  task automatic send_item(logic [1:0] op, logic [13:0] idx, logic [31:0] val,
                           logic [15:0] x, logic [15:0] y);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    store_index_i <= idx;
    write_value_i <= val;
    pixel_x_i <= x;
    pixel_y_i <= y;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(op, idx, val, x, y);
  endtask

  // loads any entry the fetch would read before it was ever written
  task automatic fetch(logic [15:0] x, logic [15:0] y);
    int mc, sa;
    void'(sb.locate(64'(x), 64'(y), mc, sa));
    if (mc >= 0 && !sb.map_loaded[mc]) begin
      send_item(tpc_pkg::OP_MAP_WR, 14'(mc), sb.pick_tile(), 16'($urandom),
                16'($urandom));
      void'(sb.locate(64'(x), 64'(y), mc, sa));
    end
    if (sa >= 0 && !sb.sheet_loaded[sa])
      send_item(tpc_pkg::OP_SHEET_WR, 14'(sa), $urandom, 16'($urandom), 16'($urandom));
    send_item(tpc_pkg::OP_FETCH, 14'($urandom), $urandom, x, y);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pixel_q.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  task automatic configure(logic [14:0] ts, logic [14:0] mw, logic [14:0] mh,
                           logic [14:0] sw, logic [14:0] sh);
    settle();
    write_reg(tpc_pkg::REG_TILE_SIZE, ts);
    write_reg(tpc_pkg::REG_MAP_WIDTH, mw);
    write_reg(tpc_pkg::REG_MAP_HEIGHT, mh);
    write_reg(tpc_pkg::REG_SHEET_WIDTH, sw);
    write_reg(tpc_pkg::REG_SHEET_HEIGHT, sh);
    @(posedge clk_i);
  endtask

  task automatic random_items(int unsigned n);
    int unsigned r;
    longint unsigned w, h;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      w = sb.map_w * sb.tsz;
      h = sb.map_h * sb.tsz;
      if (r < 45) begin
        if (w > 0 && h > 0 && $urandom_range(0, 99) < 85)
          fetch(16'($urandom_range(0, 32'(w > 65536 ? 65535 : w - 1))),
                16'($urandom_range(0, 32'(h > 65536 ? 65535 : h - 1))));
        else
          fetch(16'($urandom), 16'($urandom));
      end else if (r < 70) begin
        send_item(tpc_pkg::OP_MAP_WR,
                  14'(($urandom_range(0, 99) < 85) ?
                      $urandom_range(0, MAP_CELLS - 1) : $urandom),
                  sb.pick_tile(), 16'($urandom), 16'($urandom));
      end else if (r < 95) begin
        send_item(tpc_pkg::OP_SHEET_WR, 14'($urandom), $urandom, 16'($urandom),
                  16'($urandom));
      end else begin
        send_item(OP_UNUSED, 14'($urandom), $urandom, 16'($urandom), 16'($urandom));
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 256x256 image, 16 tiles per sheet row
    fetch(16'd0, 16'd0);
    fetch(16'd255, 16'd255);
    fetch(16'd256, 16'd0);
    fetch(16'd0, 16'd256);
    fetch(16'hFFFF, 16'hFFFF);
    send_item(tpc_pkg::OP_MAP_WR, 14'd1023, 32'hFFFF_FFFF, 16'd0, 16'd0);
    fetch(16'd248, 16'd248);  // tile row far past the sheet
    send_item(tpc_pkg::OP_MAP_WR, 14'h3FFF, 32'h0, 16'd0, 16'd0);  // beyond map store
    send_item(OP_UNUSED, 14'h3FFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_item(tpc_pkg::OP_SHEET_WR, 14'h3FFF, 32'hFFFF_FFFF, 16'd0, 16'd0);
    send_item(tpc_pkg::OP_MAP_WR, 14'd0, 32'h0000_00FF, 16'd0, 16'd0);
    fetch(16'd7, 16'd7);
    send_item(tpc_pkg::OP_SHEET_WR, 14'd0, 32'h0, 16'd0, 16'd0);
    fetch(16'd8, 16'd0);
    random_items(175);

    // one-pixel tiles, wide map: cell past map store, address past sheet
    configure(15'd1, 15'd1024, 15'd2, 15'd16384, 15'd4);
    fetch(16'd5, 16'd1);
    send_item(tpc_pkg::OP_MAP_WR, 14'd5, 32'h0000_4003, 16'd0, 16'd0);
    fetch(16'd5, 16'd0);
    random_items(175);

    configure(15'd64, 15'd16, 15'd16, 15'd256, 15'd256);
    random_items(175);

    // all-ones writes, registers above their stated range
    configure(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    fetch(16'd0, 16'd0);
    random_items(120);

    configure(15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
    fetch(16'd0, 16'd0);
    random_items(60);

    configure(15'd8, 15'd4, 15'd4, 15'd4, 15'd128);  // no whole tile fits in a sheet row
    random_items(80);

    configure(15'd4, 15'd32, 15'd32, 15'd64, 15'd64);
    random_items(175);

    for (int p = 0; p < 5; p++) begin
      configure(15'($urandom_range(1, 8)), 15'($urandom_range(1, 40)),
                15'($urandom_range(1, 40)), 15'($urandom_range(1, 128)),
                15'($urandom_range(1, 128)));
      random_items(160);
    end

    settle();
    if (sb.mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
